### hw/rtl/sit_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sit_pkg
// Shared types and codes for the SysTick-style interval timer.
// ----------------------------------------------------------------------------
package sit_pkg;

    localparam int DATA_WIDTH     = 24;
    localparam int FLAG_POS       = 16;
    localparam int PRESCALE_BITS  = 2;

    // mode codes
    localparam logic [1:0] MODE_TICK  = 2'd0;
    localparam logic [1:0] MODE_READ  = 2'd1;
    localparam logic [1:0] MODE_WRITE = 2'd2;

    // register addresses
    localparam logic [1:0] ADDR_CTRL    = 2'd0;
    localparam logic [1:0] ADDR_LOAD    = 2'd1;
    localparam logic [1:0] ADDR_VAL     = 2'd2;
    localparam logic [1:0] ADDR_ELAPSED = 2'd3;

    typedef struct packed {
        logic [1:0]            mode;
        logic [1:0]            reg_addr;
        logic [DATA_WIDTH-1:0] write_data;
    } sit_in_t;

    typedef struct packed {
        logic [DATA_WIDTH-1:0] read_data;
        logic                  irq;
    } sit_out_t;

endpackage

### hw/rtl/systick_interval_timer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// systick_interval_timer_core
// SysTick-style down-counter with CTRL, LOAD, VAL and ELAPSED registers.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one word per item: a tick (mode 0), a register read (mode 1)
//   or a register write (mode 2). Every accepted word yields exactly one
//   result word on m_*: read_data for reads (zero otherwise) and irq for a
//   tick that took the count from one to zero with interrupts enabled.
//   cfg_* writes the one-shot bit; cfg_ready is always high. Write it only
//   while no words are in flight.
// Timing:
//   State is updated in the cycle a word is accepted; its result is held in
//   the output register, or the skid register while m_* stalls. One word per
//   cycle while m_ready is high, set by the single decrement/compare path.
// Stall:
//   A two-word output buffer (result plus skid register) lets one more word
//   in while a result waits; s_ready drops only once the skid is occupied.
// Reset:
//   aresetn (synchronous, low) clears all timer state and the one-shot bit
//   and empties both buffer slots. No result is pending afterwards.
// ----------------------------------------------------------------------------
module systick_interval_timer_core #(
    parameter int COUNTER_WIDTH = 24
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  sit_pkg::sit_in_t s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output sit_pkg::sit_out_t m_data,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic             cfg_data
);
    import sit_pkg::*;

    localparam logic [COUNTER_WIDTH-1:0] CNT_ONE  = COUNTER_WIDTH'(1);
    localparam logic [COUNTER_WIDTH-1:0] CNT_ZERO = '0;

    // timer state
    logic                     one_shot_reg;
    logic                     enable_reg, enable_next;
    logic                     inten_reg, inten_next;
    logic                     clksrc_reg, clksrc_next;
    logic                     flag_reg, flag_next;
    logic [COUNTER_WIDTH-1:0] load_reg, load_next;
    logic [COUNTER_WIDTH-1:0] val_reg, val_next;
    logic [PRESCALE_BITS-1:0] presc_reg, presc_next;

    logic                     accept;
    logic                     do_count;
    logic [COUNTER_WIDTH-1:0] wdata_cnt;   // write data at counter width
    logic [COUNTER_WIDTH-1:0] rd_cnt;      // counter-width read source
    logic [DATA_WIDTH-1:0]    rd_cnt_ext;  // same, fitted to the read field
    sit_out_t                 res;
    logic                     buf_ready;

    assign accept    = s_valid && buf_ready;
    assign s_ready   = buf_ready;
    assign cfg_ready = 1'b1;

    // width fitting between the 24-bit fields and the counter
    generate
        if (COUNTER_WIDTH >= DATA_WIDTH) begin : g_wide
            if (COUNTER_WIDTH > DATA_WIDTH) begin : g_ext
                assign wdata_cnt = {{(COUNTER_WIDTH-DATA_WIDTH){1'b0}}, s_data.write_data};
            end else begin : g_eq
                assign wdata_cnt = s_data.write_data;
            end
            assign rd_cnt_ext = rd_cnt[DATA_WIDTH-1:0];
        end else begin : g_narrow
            assign wdata_cnt  = s_data.write_data[COUNTER_WIDTH-1:0];
            assign rd_cnt_ext = {{(DATA_WIDTH-COUNTER_WIDTH){1'b0}}, rd_cnt};
        end
    endgenerate

    // counter source for reads of LOAD, VAL and ELAPSED
    always_comb begin
        unique case (s_data.reg_addr)
            ADDR_LOAD: rd_cnt = load_reg;
            ADDR_VAL:  rd_cnt = val_reg;
            default:   rd_cnt = load_reg - val_reg;
        endcase
    end

    // enabled count event: each tick if clock-source is 1, else prescaler wrap
    assign do_count = (s_data.mode == MODE_TICK) && enable_reg &&
                      (clksrc_reg || (presc_reg == {PRESCALE_BITS{1'b1}}));

    always_comb begin
        enable_next = enable_reg;
        inten_next  = inten_reg;
        clksrc_next = clksrc_reg;
        flag_next   = flag_reg;
        load_next   = load_reg;
        val_next    = val_reg;
        presc_next  = presc_reg;
        res         = '0;

        unique case (s_data.mode)
            MODE_TICK: begin
                if (enable_reg && !clksrc_reg) begin
                    presc_next = presc_reg + PRESCALE_BITS'(1);
                end
                if (do_count) begin
                    if (val_reg == CNT_ZERO) begin
                        val_next = load_reg;
                    end else begin
                        val_next = val_reg - CNT_ONE;
                        if (val_reg == CNT_ONE) begin
                            // expiry
                            flag_next = 1'b1;
                            res.irq   = inten_reg;
                            if (one_shot_reg) begin
                                enable_next = 1'b0;
                                inten_next  = 1'b0;
                                load_next   = '0;
                            end
                        end
                    end
                end
            end
            MODE_READ: begin
                if (s_data.reg_addr == ADDR_CTRL) begin
                    res.read_data[0]        = enable_reg;
                    res.read_data[1]        = inten_reg;
                    res.read_data[2]        = clksrc_reg;
                    res.read_data[FLAG_POS] = flag_reg;
                    flag_next               = 1'b0;
                end else begin
                    res.read_data = rd_cnt_ext;
                end
            end
            MODE_WRITE: begin
                unique case (s_data.reg_addr)
                    ADDR_CTRL: begin
                        enable_next = s_data.write_data[0];
                        inten_next  = s_data.write_data[1];
                        clksrc_next = s_data.write_data[2];
                    end
                    ADDR_LOAD: load_next = wdata_cnt;
                    ADDR_VAL: begin
                        val_next  = '0;
                        flag_next = 1'b0;
                    end
                    default: ; // ELAPSED is read only
                endcase
            end
            default: ; // unused mode: no effect
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            one_shot_reg <= 1'b0;
            enable_reg   <= 1'b0;
            inten_reg    <= 1'b0;
            clksrc_reg   <= 1'b0;
            flag_reg     <= 1'b0;
            load_reg     <= '0;
            val_reg      <= '0;
            presc_reg    <= '0;
        end else begin
            if (cfg_valid) begin
                one_shot_reg <= cfg_data;
            end
            if (accept) begin
                enable_reg <= enable_next;
                inten_reg  <= inten_next;
                clksrc_reg <= clksrc_next;
                flag_reg   <= flag_next;
                load_reg   <= load_next;
                val_reg    <= val_next;
                presc_reg  <= presc_next;
            end
        end
    end

    sit_out_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (buf_ready),
        .in_data   (res),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (m_data)
    );

endmodule

### hw/rtl/sit_out_buf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sit_out_buf
// Two-word result buffer: output register plus skid register.
// ----------------------------------------------------------------------------
module sit_out_buf (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  sit_pkg::sit_out_t in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output sit_pkg::sit_out_t out_data
);
    import sit_pkg::*;

    logic     main_valid_reg, main_valid_next;
    logic     skid_valid_reg, skid_valid_next;
    sit_out_t main_reg, main_next;
    sit_out_t skid_reg, skid_next;
    logic     push;

    assign in_ready  = !skid_valid_reg;
    assign push      = in_valid && !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;

    always_comb begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next       = main_reg;
        skid_next       = skid_reg;
        if (!main_valid_reg || out_ready) begin
            if (skid_valid_reg) begin
                main_next       = skid_reg;
                main_valid_next = 1'b1;
                skid_valid_next = 1'b0;
            end else begin
                main_valid_next = push;
                if (push) begin
                    main_next = in_data;
                end
            end
        end else if (push) begin
            skid_next       = in_data;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

endmodule
